@@ hdl/ttd_pkg.sv @@
// Package with the widths, types, constants and arctangent table of the turn toggle deflection block.
`default_nettype none
package ttd_pkg;

  localparam int COORD_WIDTH    = 24;
  localparam int ANGLE_WIDTH    = 16;
  localparam int CORDIC_STEPS   = 30;
  localparam int PRESCALE_SHIFT = 20;
  localparam int DIFF_W         = COORD_WIDTH + 1;
  localparam int CW             = DIFF_W + PRESCALE_SHIFT + 3;
  localparam int ZW             = 32;
  localparam int STEP_W         = 5;
  localparam int DEF_W          = 8;
  localparam int DIV_STEPS      = 8;
  localparam int DIV_STEP_W     = 3;
  localparam int TERM_W         = ANGLE_WIDTH + 7;
  localparam int NUM_W          = ANGLE_WIDTH + 15;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = ANGLE_WIDTH;

  localparam logic [ANGLE_WIDTH-1:0] LO_ARC_RESET =
    ANGLE_WIDTH'(((2 ** ANGLE_WIDTH) * 8 + 180) / 360);
  localparam logic [ANGLE_WIDTH-1:0] HI_ARC_RESET =
    ANGLE_WIDTH'(((2 ** ANGLE_WIDTH) * 30 + 180) / 360);
  localparam logic [ZW-1:0] HALF_TURN  = ZW'(1) << (ZW - 1);
  localparam logic [ZW-1:0] ANG_ROUND  = ZW'(1) << (ZW - 1 - ANGLE_WIDTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LO_ARC = 2'd0,
    CFG_HI_ARC = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic                          cw_turn;
  } in_item_t;

  typedef struct packed {
    logic [DEF_W-1:0]       left_deflect;
    logic [DEF_W-1:0]       right_deflect;
    logic [ANGLE_WIDTH-1:0] arc_angle;
  } out_item_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [ZW-1:0]        z;
    logic                 zero;
  } cordic_vec_t;

  typedef struct packed {
    logic        valid;
    logic        right;
    logic        same;
    cordic_vec_t va;
    cordic_vec_t vb;
  } cordic_lane_t;

  typedef struct packed {
    logic                   valid;
    logic                   right;
    logic [ANGLE_WIDTH-1:0] arc;
    logic [NUM_W-1:0]       rem;
    logic [TERM_W-1:0]      den;
    logic [DEF_W-1:0]       quot;
  } div_lane_t;

  function automatic logic [ZW-1:0] atan_lut(input logic [STEP_W-1:0] idx);
    logic [ZW-1:0] r;
    case (idx)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10679838;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41722;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      5'd24:   r = 32'd41;
      5'd25:   r = 32'd20;
      5'd26:   r = 32'd10;
      5'd27:   r = 32'd5;
      5'd28:   r = 32'd3;
      5'd29:   r = 32'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/ttd_if.sv @@
// Valid/ready channel interfaces for the turn beats and the deflection beats.
`default_nettype none
interface ttd_in_if import ttd_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ttd_out_if import ttd_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/ttd_cordic_cell.sv @@
// One vectoring CORDIC cell that turns both bearing vectors by one micro-rotation.
`default_nettype none
module ttd_cordic_cell import ttd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic [STEP_W-1:0] step_i,
  input  wire cordic_lane_t lane_i,
  output cordic_lane_t      lane_o
);

  cordic_lane_t lane_d, lane_q;

  function automatic cordic_vec_t rotate(input cordic_vec_t v, input logic [STEP_W-1:0] s);
    cordic_vec_t          r;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic [ZW-1:0]        a;
    xs = v.x >>> s;
    ys = v.y >>> s;
    a  = atan_lut(s);
    r  = v;
    if (v.y > 0) begin
      r.x = v.x + ys;
      r.y = v.y - xs;
      r.z = v.z + a;
    end else begin
      r.x = v.x - ys;
      r.y = v.y + xs;
      r.z = v.z - a;
    end
    return r;
  endfunction

  always_comb begin
    lane_d    = lane_i;
    lane_d.va = rotate(lane_i.va, step_i);
    lane_d.vb = rotate(lane_i.vb, step_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q.valid <= 1'b0;
    end else if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule
`default_nettype wire

@@ hdl/ttd_div_cell.sv @@
// One restoring division cell that settles one quotient bit of the deflection.
`default_nettype none
module ttd_div_cell import ttd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic [DIV_STEP_W-1:0] step_i,
  input  wire div_lane_t             lane_i,
  output div_lane_t                  lane_o
);

  div_lane_t        lane_d, lane_q;
  logic [NUM_W-1:0] den_sh;
  logic             ge;

  always_comb begin
    den_sh = NUM_W'(lane_i.den) << step_i;
    ge     = lane_i.rem >= den_sh;
    lane_d = lane_i;
    lane_d.rem  = ge ? (lane_i.rem - den_sh) : lane_i.rem;
    lane_d.quot = {lane_i.quot[DEF_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q.valid <= 1'b0;
    end else if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule
`default_nettype wire

@@ hdl/turn_toggle_deflection_core.sv @@
// Top level of the turn toggle deflection block: bearing cells, arc, band and divider cells.
// Usage: each beat on in_i carries one circular turn (start, end, centre, direction).
// Each beat on out_o carries the left and right toggle pull and the swept arc, one
// result per turn, in the order the turns were taken.
// From the accepting edge to out_o.valid, a register forms the centre-relative vectors,
// 30 CORDIC cells form both bearings side by side, then registers hold the arc, the band
// selection and the numerator, followed by eight restoring division cells and the
// output register. Throughput is one turn per cycle while in_i.ready is high; every cell
// hands its data on each enabled cycle.
// The two turn registers are written through cfg_we_i, cfg_idx_i and cfg_data_i, other
// indexes are ignored; the user must write only while the block is idle, it is not enforced.
// Reset clears all valid flags and loads the default minimum and maximum turn.
// When the receiver stalls, the output register holds its beat and a skid register
// takes one more; in_i.ready then falls and the whole chain holds until the skid
// register drains.
`default_nettype none
module turn_toggle_deflection_core import ttd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  ttd_in_if.sink                     in_i,
  ttd_out_if.source                  out_o
);

  logic [ANGLE_WIDTH-1:0] lo_arc_q, hi_arc_q;
  logic                   en;

  cordic_lane_t cl [0:CORDIC_STEPS];
  cordic_lane_t pre_d;
  div_lane_t    dl [0:DIV_STEPS];

  logic                   arc_valid_q, arc_right_q;
  logic [ANGLE_WIDTH-1:0] arc_q, arc_d;

  logic                   band_valid_q, band_right_q;
  logic [ANGLE_WIDTH-1:0] band_arc_q;
  logic [TERM_W-1:0]      term_q, term_d, den_q, den_d;

  div_lane_t num_d;

  logic      out_valid_q, skid_valid_q;
  out_item_t out_q, skid_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_arc_q <= LO_ARC_RESET;
      hi_arc_q <= HI_ARC_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LO_ARC: lo_arc_q <= cfg_data_i;
        CFG_HI_ARC: hi_arc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en       = !skid_valid_q;
  assign in_i.ready = en;

  function automatic cordic_vec_t init_vec(
    input logic signed [COORD_WIDTH-1:0] px, input logic signed [COORD_WIDTH-1:0] py,
    input logic signed [COORD_WIDTH-1:0] cx, input logic signed [COORD_WIDTH-1:0] cy);
    cordic_vec_t              v;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [CW-1:0]     e;
    logic signed [CW-1:0]     n;
    dx = DIFF_W'(px) - DIFF_W'(cx);
    dy = DIFF_W'(py) - DIFF_W'(cy);
    e  = CW'(dx) <<< PRESCALE_SHIFT;
    n  = CW'(dy) <<< PRESCALE_SHIFT;
    v.zero = (dx == '0) && (dy == '0);
    if (n < 0) begin
      v.x = -n;
      v.y = -e;
      v.z = HALF_TURN;
    end else begin
      v.x = n;
      v.y = e;
      v.z = '0;
    end
    return v;
  endfunction

  always_comb begin
    pre_d.valid = in_i.valid;
    pre_d.right = in_i.data.cw_turn;
    pre_d.same  = (in_i.data.start_x == in_i.data.end_x) &&
                  (in_i.data.start_y == in_i.data.end_y);
    pre_d.va = init_vec(in_i.data.start_x, in_i.data.start_y,
                        in_i.data.center_x, in_i.data.center_y);
    pre_d.vb = init_vec(in_i.data.end_x, in_i.data.end_y,
                        in_i.data.center_x, in_i.data.center_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cl[0].valid <= 1'b0;
    end else if (en) begin
      cl[0] <= pre_d;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    ttd_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .step_i (STEP_W'(k)),
      .lane_i (cl[k]),
      .lane_o (cl[k+1])
    );
  end

  function automatic logic [ANGLE_WIDTH-1:0] round_bearing(input cordic_vec_t v);
    logic [ZW-1:0] s;
    s = v.z + ANG_ROUND;
    return v.zero ? '0 : s[ZW-1 -: ANGLE_WIDTH];
  endfunction

  always_comb begin
    logic [ANGLE_WIDTH-1:0] a1;
    logic [ANGLE_WIDTH-1:0] a2;
    a1 = round_bearing(cl[CORDIC_STEPS].va);
    a2 = round_bearing(cl[CORDIC_STEPS].vb);
    if (cl[CORDIC_STEPS].same) begin
      arc_d = '0;
    end else if (cl[CORDIC_STEPS].right) begin
      arc_d = a2 - a1;
    end else begin
      arc_d = a1 - a2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arc_valid_q <= 1'b0;
    end else if (en) begin
      arc_valid_q <= cl[CORDIC_STEPS].valid;
      arc_right_q <= cl[CORDIC_STEPS].right;
      arc_q       <= arc_d;
    end
  end

  always_comb begin
    logic [ANGLE_WIDTH-1:0] span;
    logic [ANGLE_WIDTH-1:0] over;
    span = hi_arc_q - lo_arc_q;
    over = arc_q - lo_arc_q;
    if (arc_q < lo_arc_q) begin
      term_d = TERM_W'(arc_q);
      den_d  = TERM_W'(lo_arc_q) * TERM_W'(100);
    end else if (arc_q < hi_arc_q) begin
      term_d = TERM_W'(span) + TERM_W'(over) * TERM_W'(99);
      den_d  = TERM_W'(span) * TERM_W'(100);
    end else begin
      term_d = TERM_W'(1);
      den_d  = TERM_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_valid_q <= 1'b0;
    end else if (en) begin
      band_valid_q <= arc_valid_q;
      band_right_q <= arc_right_q;
      band_arc_q   <= arc_q;
      term_q       <= term_d;
      den_q        <= den_d;
    end
  end

  always_comb begin
    num_d.valid = band_valid_q;
    num_d.right = band_right_q;
    num_d.arc   = band_arc_q;
    num_d.rem   = (NUM_W'(term_q) << 8) - NUM_W'(term_q);
    num_d.den   = den_q;
    num_d.quot  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl[0].valid <= 1'b0;
    end else if (en) begin
      dl[0] <= num_d;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    ttd_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .step_i (DIV_STEP_W'(DIV_STEPS - 1 - k)),
      .lane_i (dl[k]),
      .lane_o (dl[k+1])
    );
  end

  always_comb begin
    res_d.left_deflect  = dl[DIV_STEPS].right ? '0 : dl[DIV_STEPS].quot;
    res_d.right_deflect = dl[DIV_STEPS].right ? dl[DIV_STEPS].quot : '0;
    res_d.arc_angle     = dl[DIV_STEPS].arc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_o.ready || !out_valid_q) begin
      out_valid_q  <= skid_valid_q || dl[DIV_STEPS].valid;
      out_q        <= skid_valid_q ? skid_q : res_d;
      skid_valid_q <= 1'b0;
    end else if (en && dl[DIV_STEPS].valid) begin
      skid_valid_q <= 1'b1;
      skid_q       <= res_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule
`default_nettype wire

@@ hdl/ttd_checker.sv @@
// Port checker for the turn toggle deflection block and its bind to the top level.
`default_nettype none
module ttd_checker import ttd_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_ready_i,
  input wire logic      out_valid_i,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Output beat withdrawn while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("Output beat changed while stalled.");

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.left_deflect == '0) || (out_data_i.right_deflect == '0))
    else $error("Both toggles deflected at once.");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i && in_ready_i)
    else $error("Output valid or input stalled during reset.");

endmodule

bind turn_toggle_deflection_core ttd_checker u_ttd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench for the turn toggle deflection core: directed table, random turns, bearing predictor.
`default_nettype none
module tb_top;
  import ttd_pkg::*;

  localparam int LATENCY = 43;

  typedef struct {
    in_item_t  turn;
    bit        known;
    out_item_t res;
  } turn_row_t;

  typedef struct {
    logic [CFG_DATA_W-1:0] lo_arc;
    logic [CFG_DATA_W-1:0] hi_arc;
  } turn_setting_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  ttd_in_if  turn_ch ();
  ttd_out_if pull_ch ();

  turn_toggle_deflection_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (turn_ch),
    .out_o      (pull_ch)
  );

  logic [ZW-1:0] arctan_steps [CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1
  };

  logic [ANGLE_WIDTH-1:0] lo_arc_q = LO_ARC_RESET;
  logic [ANGLE_WIDTH-1:0] hi_arc_q = HI_ARC_RESET;
  out_item_t pull_queue [$];
  int mismatches = 0;
  int hold_cycles = 0;
  bit long_hold_req = 1'b0;
  bit long_hold_ack = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("tb_top failed");
    $finish;
  end

  function automatic logic [ANGLE_WIDTH-1:0] compass_bearing(longint east, longint north);
    longint x, y, nx;
    logic [ZW-1:0] z;
    logic [ZW:0] rounded;
    if (east == 0 && north == 0) return '0;
    x = north * 1048576;
    y = east * 1048576;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + arctan_steps[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - arctan_steps[i];
      end
      x = nx;
    end
    rounded = {1'b0, z} + (33'd1 << (31 - ANGLE_WIDTH));
    return rounded[ZW-1 -: ANGLE_WIDTH];
  endfunction

  function automatic out_item_t toggle_pull(in_item_t t);
    out_item_t r;
    longint sx, sy, ex, ey, cx, cy;
    logic [ANGLE_WIDTH-1:0] a1, a2, arc;
    longint unsigned mn, mx, span, defl;
    sx = longint'(t.start_x);
    sy = longint'(t.start_y);
    ex = longint'(t.end_x);
    ey = longint'(t.end_y);
    cx = longint'(t.center_x);
    cy = longint'(t.center_y);
    arc = '0;
    if (!(sx == ex && sy == ey)) begin
      a1 = compass_bearing(sx - cx, sy - cy);
      a2 = compass_bearing(ex - cx, ey - cy);
      arc = t.cw_turn ? a2 - a1 : a1 - a2;
    end
    mn = lo_arc_q;
    mx = hi_arc_q;
    if (arc < mn) begin
      defl = (255 * longint'(arc)) / (100 * mn);
    end else if (arc < mx) begin
      span = mx - mn;
      defl = (255 * (span + 99 * (arc - mn))) / (100 * span);
    end else begin
      defl = 255;
    end
    r.left_deflect = t.cw_turn ? '0 : defl[7:0];
    r.right_deflect = t.cw_turn ? defl[7:0] : '0;
    r.arc_angle = arc;
    return r;
  endfunction

  function automatic in_item_t make_turn(logic signed [23:0] sx, logic signed [23:0] sy,
                                         logic signed [23:0] ex, logic signed [23:0] ey,
                                         logic signed [23:0] cx, logic signed [23:0] cy,
                                         logic rt);
    in_item_t t;
    t.start_x = sx;
    t.start_y = sy;
    t.end_x = ex;
    t.end_y = ey;
    t.center_x = cx;
    t.center_y = cy;
    t.cw_turn = rt;
    return t;
  endfunction

  function automatic logic signed [23:0] edge_coord();
    case ($urandom_range(0, 4))
      0: return 24'sh800000;
      1: return 24'sh7fffff;
      2: return '0;
      3: return -24'sd1;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic signed [23:0] near(logic signed [23:0] c);
    int r;
    r = (1 << $urandom_range(1, 22));
    return c + 24'($signed($urandom_range(0, 2 * r)) - r);
  endfunction

  function automatic in_item_t random_turn();
    in_item_t t;
    logic signed [23:0] cx, cy;
    cx = 24'($urandom);
    cy = 24'($urandom);
    t = make_turn(near(cx), near(cy), near(cx), near(cy), cx, cy, 1'($urandom));
    case ($urandom_range(0, 9))
      0: t = make_turn(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                       24'($urandom), 24'($urandom), 1'($urandom));
      1: begin
        t.end_x = t.start_x;
        t.end_y = t.start_y;
      end
      2: begin
        t.start_x = cx;
        t.start_y = cy;
      end
      3: begin
        t.end_x = cx;
        t.end_y = cy;
      end
      4: t = make_turn(edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                       edge_coord(), edge_coord(), 1'($urandom));
      default: ;
    endcase
    return t;
  endfunction

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_turn(in_item_t t);
    int g;
    turn_ch.valid <= 1'b1;
    turn_ch.data <= t;
    do @(posedge clk_i); while (!turn_ch.ready);
    g = gap_length();
    if (g > 0) begin
      turn_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    wait (pull_queue.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_turn_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_LO_ARC) lo_arc_q = val;
    else if (idx == CFG_HI_ARC) hi_arc_q = val;
  endtask

  always @(posedge clk_i) begin
    out_item_t got, want;
    if (turn_ch.valid && turn_ch.ready) pull_queue.push_back(toggle_pull(turn_ch.data));
    if (pull_ch.valid && pull_ch.ready) begin
      got = pull_ch.data;
      if (pull_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", got);
      end else begin
        want = pull_queue.pop_front();
        if (got.left_deflect !== want.left_deflect || got.right_deflect !== want.right_deflect
            || got.arc_angle !== want.arc_angle) begin
          mismatches++;
          if (mismatches <= 10) $display("beat mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (long_hold_req != long_hold_ack) begin
      pull_ch.ready <= 1'b0;
      hold_cycles <= 300;
      long_hold_ack <= long_hold_req;
    end else if (hold_cycles > 0) begin
      pull_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if ($urandom_range(0, 99) < 4) begin
      pull_ch.ready <= 1'b0;
      hold_cycles <= $urandom_range(0, 99) < 80 ? $urandom_range(0, 2) : $urandom_range(8, 30);
    end else begin
      pull_ch.ready <= 1'b1;
    end
  end

  initial begin
    turn_row_t rows [$];
    turn_setting_t phases [$];
    out_item_t zero_pull;
    out_item_t row_pull;
    zero_pull = '0;
    turn_ch.valid = 1'b0;
    turn_ch.data = '0;
    pull_ch.ready = 1'b0;

    rows.push_back('{make_turn(0, 0, 0, 0, 0, 0, 1'b1), 1'b1, zero_pull});
    rows.push_back('{make_turn(24'sh7fffff, 24'sh800000, 24'sh7fffff, 24'sh800000,
                               0, 0, 1'b0), 1'b1, zero_pull});
    rows.push_back('{make_turn(0, 100, 100, 0, 0, 0, 1'b1), 1'b0, zero_pull});
    rows.push_back('{make_turn(0, 100, 100, 0, 0, 0, 1'b0), 1'b0, zero_pull});
    rows.push_back('{make_turn(0, 0, 50, 50, 0, 0, 1'b1), 1'b0, zero_pull});
    rows.push_back('{make_turn(5, 5, 5, -7, 5, 5, 1'b0), 1'b0, zero_pull});
    rows.push_back('{make_turn(0, -100, -100, 0, 0, 0, 1'b1), 1'b0, zero_pull});
    rows.push_back('{make_turn(1000, 1000, 1003, 999, 0, 0, 1'b1), 1'b0, zero_pull});
    rows.push_back('{make_turn(1000, 0, 990, 150, 0, 0, 1'b0), 1'b0, zero_pull});
    rows.push_back('{make_turn(24'sh7fffff, 24'sh7fffff, 24'sh800000, 24'sh800000,
                               24'sh800000, 24'sh7fffff, 1'b1), 1'b0, zero_pull});
    rows.push_back('{make_turn(24'sh800000, 24'sh800000, 24'sh7fffff, 24'sh800000,
                               24'sh7fffff, 24'sh7fffff, 1'b0), 1'b0, zero_pull});
    rows.push_back('{make_turn(-1, -1, 1, -1, 0, 0, 1'b1), 1'b0, zero_pull});
    rows.push_back('{make_turn(1, 0, 0, 1, 0, 0, 1'b1), 1'b0, zero_pull});
    rows.push_back('{make_turn(0, 1, 0, -1, 0, 0, 1'b0), 1'b0, zero_pull});
    rows.push_back('{make_turn(-5, 3, -5, 3, 7, 7, 1'b0), 1'b1, zero_pull});

    phases.push_back('{LO_ARC_RESET, HI_ARC_RESET});
    phases.push_back('{16'd1, 16'd2});
    phases.push_back('{16'd1, 16'hffff});
    phases.push_back('{16'hffff, 16'd2});
    phases.push_back('{16'd0, 16'd300});
    phases.push_back('{16'hffff, 16'hffff});
    phases.push_back('{16'd200, 16'd12000});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].known) begin
        row_pull = toggle_pull(rows[i].turn);
        if (row_pull !== rows[i].res) begin
          mismatches++;
          if (mismatches <= 10) $display("row mismatch: expected %p, got %p",
                                         rows[i].res, row_pull);
        end
      end
      send_turn(rows[i].turn);
      if (rows[i].known) begin
        turn_ch.valid <= 1'b0;
        drain_results();
      end
    end
    turn_ch.valid <= 1'b0;
    drain_results();

    foreach (phases[p]) begin
      if (p > 0) begin
        write_turn_reg(CFG_LO_ARC, phases[p].lo_arc);
        write_turn_reg(CFG_HI_ARC, phases[p].hi_arc);
        write_turn_reg(2'd2, 16'($urandom));
        write_turn_reg(2'd3, 16'($urandom));
      end
      for (int n = 0; n < 115; n++) begin
        if (p == 1 && n == 20) long_hold_req = ~long_hold_req;
        if (p == 2 && n == 50) begin
          turn_ch.valid <= 1'b0;
          wait (pull_queue.size() == 0);
          @(posedge clk_i);
        end
        send_turn(random_turn());
      end
      turn_ch.valid <= 1'b0;
      drain_results();
    end

    if (mismatches == 0 && pull_queue.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
